FILE: hdl/ffba_pkg.sv
package ffba_pkg;

  localparam int FREE_SLOTS = 16;
  localparam int HELD_SLOTS = 16;
  localparam int FIDX_W = $clog2(FREE_SLOTS);
  localparam int HIDX_W = $clog2(HELD_SLOTS);
  localparam int FCNT_W = $clog2(FREE_SLOTS + 1);

  typedef enum logic [1:0] {
    CMD_RESERVE = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_DEFRAG  = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_FIT   = 3'd1,
    ST_NOT_HELD = 3'd2,
    ST_OVERLAP  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  localparam logic [0:0] CFG_BASE = 1'b0;
  localparam logic [0:0] CFG_SIZE = 1'b1;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
  } entry_t;

  // Commands from the sequencer to the free-table chain.
  typedef struct packed {
    logic        init;      // load entry zero with the region, clear the rest
    logic        carve;     // shrink entry idx by amount from the front
    logic        insert;    // shift entries at and above idx up, put ins there
    logic        merge;     // merge entry idx with its neighbour and shift down
    logic        rotate;    // move every entry one place toward slot zero, head wrapping to the top
    logic [FIDX_W-1:0] idx;
    logic [31:0] amount;
    entry_t      ins;
  } fcmd_t;

endpackage

FILE: hdl/first_fit_block_allocator.sv
// Reserve, free and no-op run the held scan, free scan, decide, edit, statistics and
// reserved-total steps before m_tvalid rises; defragment skips the free scan and decide step and
// adds one more pair-search scan and edit pass per merged entry.
// Throughput is one request at a time: s_tready returns once the result is taken and the block is idle.
// Reset (rst, synchronous) loads region base 0, size 65536 and the initial tables; a
// configuration write reinitializes both tables and holds s_tready low until that is done in idle.
module first_fit_block_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command[1:0], request_size[33:2], block_address[65:34], zero padded
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], granted[34:3], merged[38:35], free_total[70:39],
  // reserved_total[102:71], free_entries[107:103], largest[139:108],
  // smallest[171:140], zero padded
  output logic [175:0] m_tdata
);
  import ffba_pkg::*;

  // The free table lives in a chain of cells. Entry zero sits at the head;
  // scanning rotates the whole chain one slot per cycle so that the head
  // sees every entry in turn, and after FREE_SLOTS rotations the table is
  // back in place. Edits (carve, insert, merge) are applied at a chosen
  // slot once the scan has located it.
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_HSCAN  = 9'b000000010,
    S_FSCAN  = 9'b000000100,
    S_DECIDE = 9'b000001000,
    S_EDIT   = 9'b000010000,
    S_DSCAN  = 9'b000100000,
    S_STATS  = 9'b001000000,
    S_RTOT   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state;
  logic [31:0] region_base, region_size;
  logic        init_pend;

  cmd_t        cmd;
  logic [31:0] req_size, req_addr;

  // Held table: small register array, scanned one entry a cycle.
  logic [31:0] held_start  [HELD_SLOTS];
  logic [31:0] held_length [HELD_SLOTS];
  logic [HELD_SLOTS-1:0] held_valid;

  logic [FCNT_W-1:0] free_used;
  logic [FCNT_W-1:0] fcnt;         // rotation counter
  logic [HIDX_W:0]   hcnt;
  logic              h_found, h_free_found;
  logic [HIDX_W-1:0] h_idx, h_free_idx;
  logic              fit_found;
  logic [FIDX_W-1:0] fit_idx;
  logic [FCNT_W-1:0] pos;          // insertion point for free
  logic              ovl;
  logic [32:0]       prev_end;
  logic              prev_ok;
  logic              merge_found;
  logic [FIDX_W-1:0] merge_idx;
  logic [3:0]        merged;
  logic [2:0]        status;
  logic [31:0]       granted;
  logic [32:0]       ftot, rtot;
  logic [31:0]       big, small_len;
  // Start of the chosen fit entry, captured while the scan passes it.
  logic [31:0]       head_sel_start;

  fcmd_t  fcmd;
  entry_t head, head2, init_val;
  logic [FIDX_W-1:0] cur;   // table index now at the head

  assign init_val = '{start: region_base, length: region_size};
  assign cur = fcnt[FIDX_W-1:0];

  ffba_chain u_chain (
    .clk     (clk),
    .cmd     (fcmd),
    .init_val(init_val),
    .head    (head),
    .head2   (head2)
  );

  logic in_table;
  logic [32:0] head_end;
  assign in_table = fcnt < free_used;
  assign head_end = {1'b0, head.start} + {1'b0, head.length};

  always_comb begin
    fcmd = '0;
    fcmd.idx = '0;
    unique case (state)
      S_IDLE:   fcmd.init = rst | init_pend;
      S_FSCAN, S_STATS, S_DSCAN: fcmd.rotate = fcnt < FCNT_W'(FREE_SLOTS);
      S_EDIT: begin
        unique case (cmd)
          CMD_RESERVE: begin
            fcmd.carve  = status == ST_OK;
            fcmd.idx    = fit_idx;
            fcmd.amount = req_size;
          end
          CMD_FREE: begin
            fcmd.insert = status == ST_OK;
            fcmd.idx    = pos[FIDX_W-1:0];
            fcmd.ins    = '{start: req_addr, length: held_length[h_idx]};
          end
          CMD_DEFRAG: begin
            fcmd.merge = merge_found;
            fcmd.idx   = merge_idx;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      region_base <= '0;
      region_size <= 32'd65536;
      init_pend   <= 1'b1;
      held_valid  <= '0;
      free_used   <= FCNT_W'(1);
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_BASE) region_base <= cfg_data;
        else region_size <= cfg_data;
        init_pend <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (init_pend && !cfg_we) begin
            init_pend  <= 1'b0;
            held_valid <= '0;
            free_used  <= FCNT_W'(1);
          end else if (s_tvalid && s_tready) begin
            cmd      <= cmd_t'(s_tdata[1:0]);
            req_size <= s_tdata[33:2];
            req_addr <= s_tdata[65:34];
            hcnt <= '0; h_found <= 1'b0; h_free_found <= 1'b0;
            fcnt <= '0; fit_found <= 1'b0; pos <= free_used;
            ovl <= 1'b0; prev_ok <= 1'b0; merge_found <= 1'b0;
            merged <= '0; status <= ST_OK; granted <= '0;
            state <= S_HSCAN;
          end
        end
        S_HSCAN: begin
          if (hcnt < (HIDX_W + 1)'(HELD_SLOTS)) begin
            if (!held_valid[hcnt[HIDX_W-1:0]] && !h_free_found) begin
              h_free_found <= 1'b1; h_free_idx <= hcnt[HIDX_W-1:0];
            end
            if (held_valid[hcnt[HIDX_W-1:0]] && !h_found &&
                held_start[hcnt[HIDX_W-1:0]] == req_addr) begin
              h_found <= 1'b1; h_idx <= hcnt[HIDX_W-1:0];
            end
            hcnt <= hcnt + 1'b1;
          end else begin
            fcnt  <= '0;
            state <= (cmd == CMD_DEFRAG) ? S_DSCAN : S_FSCAN;
          end
        end
        S_FSCAN: begin
          if (fcnt < FCNT_W'(FREE_SLOTS)) begin
            if (in_table) begin
              if (!fit_found && head.length >= req_size) begin
                fit_found <= 1'b1; fit_idx <= cur;
              end
              if (pos == free_used && head.start > req_addr) begin
                pos <= fcnt;
                // following entry: freed end must not pass its start
                if ({1'b0, req_addr} + {1'b0, held_length[h_idx]} >
                    {1'b0, head.start}) ovl <= 1'b1;
              end
              if (pos == free_used && head.start <= req_addr) begin
                prev_ok  <= 1'b1;
                prev_end <= head_end;
              end
            end
            fcnt <= fcnt + 1'b1;
          end else begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          unique case (cmd)
            CMD_RESERVE: begin
              if (!fit_found) status <= ST_NO_FIT;
              else if (!h_free_found) status <= ST_FULL;
            end
            CMD_FREE: begin
              if (!h_found) status <= ST_NOT_HELD;
              else if (ovl || (prev_ok && prev_end > {1'b0, req_addr}))
                status <= ST_OVERLAP;
              else if (free_used >= FCNT_W'(FREE_SLOTS)) status <= ST_FULL;
            end
            default: ;
          endcase
          state <= S_EDIT;
        end
        S_EDIT: begin
          if (cmd == CMD_RESERVE && status == ST_OK) begin
            held_valid[h_free_idx]  <= 1'b1;
            held_start[h_free_idx]  <= head_sel_start;
            held_length[h_free_idx] <= req_size;
            granted <= head_sel_start;
          end
          if (cmd == CMD_FREE && status == ST_OK) begin
            held_valid[h_idx] <= 1'b0;
            free_used <= free_used + 1'b1;
          end
          fcnt <= '0;
          if (cmd == CMD_DEFRAG) begin
            if (merge_found) begin
              free_used <= free_used - 1'b1;
              if (merged != 4'd15) merged <= merged + 1'b1;
              merge_found <= 1'b0;
              state <= S_DSCAN;
            end else begin
              state <= S_STATS;
            end
          end else begin
            state <= S_STATS;
          end
          ftot <= '0; big <= '0; small_len <= '0;
        end
        S_DSCAN: begin
          // find the first pair of touching entries
          if (fcnt < FCNT_W'(FREE_SLOTS)) begin
            if (!merge_found && fcnt + 1'b1 < free_used &&
                head_end == {1'b0, head2.start}) begin
              merge_found <= 1'b1; merge_idx <= cur;
            end
            fcnt <= fcnt + 1'b1;
          end else begin
            state <= S_EDIT;
          end
        end
        S_STATS: begin
          if (fcnt < FCNT_W'(FREE_SLOTS)) begin
            if (in_table) begin
              ftot <= (ftot + {1'b0, head.length} > 33'h0_FFFF_FFFF) ?
                      33'h0_FFFF_FFFF : ftot + {1'b0, head.length};
              if (fcnt == '0 || head.length > big) big <= head.length;
              if (fcnt == '0 || head.length < small_len) small_len <= head.length;
            end
            fcnt <= fcnt + 1'b1;
          end else begin
            hcnt <= '0; rtot <= '0;
            state <= S_RTOT;
          end
        end
        S_RTOT: begin
          if (hcnt < (HIDX_W + 1)'(HELD_SLOTS)) begin
            if (held_valid[hcnt[HIDX_W-1:0]])
              rtot <= (rtot + {1'b0, held_length[hcnt[HIDX_W-1:0]]} >
                       33'h0_FFFF_FFFF) ? 33'h0_FFFF_FFFF :
                      rtot + {1'b0, held_length[hcnt[HIDX_W-1:0]]};
            hcnt <= hcnt + 1'b1;
          end else begin
            m_tvalid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FSCAN && in_table && !fit_found && head.length >= req_size &&
        fcnt < FCNT_W'(FREE_SLOTS))
      head_sel_start <= head.start;
  end

  assign s_tready = (state == S_IDLE) && !init_pend;

  assign m_tdata = {4'd0, small_len, big, 5'(free_used), rtot[31:0], ftot[31:0],
                    merged, granted, status};
endmodule

FILE: hdl/ffba_cell.sv
module ffba_cell (
  input  logic            clk,
  input  ffba_pkg::fcmd_t cmd,
  input  logic            first,
  input  logic            at_idx,
  input  logic            above_idx,
  input  logic            below_idx,
  input  ffba_pkg::entry_t init_val,
  input  ffba_pkg::entry_t lower,
  input  ffba_pkg::entry_t upper,
  input  logic            has_upper,
  input  logic            last,
  output ffba_pkg::entry_t q
);
  import ffba_pkg::*;

  entry_t      d;
  logic [32:0] msum;

  assign msum = {1'b0, q.length} + {1'b0, upper.length};

  always_comb begin
    d = q;
    priority if (cmd.init) begin
      d = first ? init_val : '0;
    end else if (cmd.rotate) begin
      d = has_upper ? upper : q;
    end else if (cmd.carve && at_idx) begin
      d.start  = q.start + cmd.amount;
      d.length = q.length - cmd.amount;
    end else if (cmd.insert && at_idx) begin
      d = cmd.ins;
    end else if (cmd.insert && above_idx) begin
      d = lower;
    end else if (cmd.merge && at_idx) begin
      d.length = msum[32] ? 32'hFFFF_FFFF : msum[31:0];
    end else if (cmd.merge && below_idx) begin
      d = last ? '0 : upper;
    end
  end

  always_ff @(posedge clk) begin
    q <= d;
  end
endmodule

FILE: hdl/ffba_chain.sv
module ffba_chain (
  input  logic             clk,
  input  ffba_pkg::fcmd_t  cmd,
  input  ffba_pkg::entry_t init_val,
  output ffba_pkg::entry_t head,
  output ffba_pkg::entry_t head2
);
  import ffba_pkg::*;

  entry_t q [FREE_SLOTS];

  for (genvar g = 0; g < FREE_SLOTS; g++) begin : g_cell
    localparam logic [FIDX_W-1:0] MY = FIDX_W'(g);
    localparam int UP  = (g + 1) % FREE_SLOTS;
    localparam int DN  = (g + FREE_SLOTS - 1) % FREE_SLOTS;
    logic at_i, above_i, below_i;
    assign at_i    = cmd.idx == MY;
    assign above_i = MY > cmd.idx;
    // merge shifts everything above the merged entry down by one slot
    assign below_i = MY > cmd.idx;
    ffba_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .first     (g == 0),
      .at_idx    (at_i),
      .above_idx (above_i),
      .below_idx (below_i),
      .init_val  (init_val),
      .lower     (q[DN]),
      .upper     (q[UP]),
      .has_upper (1'b1),
      .last      (g == FREE_SLOTS - 1),
      .q         (q[g])
    );
  end

  assign head  = q[0];
  assign head2 = q[1];
endmodule

FILE: bench/first_fit_block_allocator_checker.sv
// Watches the configuration port and both streaming channels of the allocator.
// It keeps its own copy of the free and reserved tables. For every accepted
// request it predicts the result, and it compares each returned result with
// the oldest prediction.
module first_fit_block_allocator_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [71:0]  s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [175:0] m_tdata,
  output int           errors,
  output int           pending
);
  import ffba_pkg::*;

  typedef struct {
    status_t     status;
    logic [31:0] granted;
    logic [3:0]  merged;
    logic [31:0] free_total;
    logic [31:0] held_total;
    logic [4:0]  free_count;
    logic [31:0] largest;
    logic [31:0] smallest;
  } alloc_result_t;

  localparam logic [63:0] SAT32 = 64'hFFFF_FFFF;

  logic [31:0] base_reg, size_reg;
  logic [31:0] fstart [FREE_SLOTS];
  logic [31:0] flen   [FREE_SLOTS];
  int          fused;
  logic [31:0] hstart [HELD_SLOTS];
  logic [31:0] hlen   [HELD_SLOTS];
  logic        hvalid [HELD_SLOTS];
  alloc_result_t expected_results[$];
  int          result_no;

  assign pending = expected_results.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH result %0d: %s got 0x%08h expected 0x%08h", result_no, what, got, want);
    errors++;
  endtask

  task automatic clear_tables();
    for (int i = 0; i < FREE_SLOTS; i++) begin
      fstart[i] = '0;
      flen[i] = '0;
    end
    for (int i = 0; i < HELD_SLOTS; i++) begin
      hstart[i] = '0;
      hlen[i] = '0;
      hvalid[i] = 1'b0;
    end
    fstart[0] = base_reg;
    flen[0] = size_reg;
    fused = 1;
  endtask

  function automatic status_t reserve_block(input logic [31:0] sz, output logic [31:0] grant);
    int i, h;
    grant = '0;
    for (i = 0; i < fused; i++)
      if (flen[i] >= sz) break;
    if (i >= fused) return ST_NO_FIT;
    for (h = 0; h < HELD_SLOTS; h++)
      if (!hvalid[h]) break;
    if (h >= HELD_SLOTS) return ST_FULL;
    hvalid[h] = 1'b1;
    hstart[h] = fstart[i];
    hlen[h] = sz;
    grant = fstart[i];
    fstart[i] = fstart[i] + sz;
    flen[i] = flen[i] - sz;
    return ST_OK;
  endfunction

  function automatic status_t release_block(input logic [31:0] ad);
    int h, p;
    logic [63:0] blk_end;
    for (h = 0; h < HELD_SLOTS; h++)
      if (hvalid[h] && hstart[h] == ad) break;
    if (h >= HELD_SLOTS) return ST_NOT_HELD;
    blk_end = {32'd0, ad} + {32'd0, hlen[h]};
    for (p = 0; p < fused; p++)
      if (fstart[p] > ad) break;
    // The freed block may neither start inside its lower neighbour nor run
    // into its upper one; ends are taken without wrap.
    if (p > 0 && ({32'd0, fstart[p-1]} + {32'd0, flen[p-1]}) > {32'd0, ad})
      return ST_OVERLAP;
    if (p < fused && blk_end > {32'd0, fstart[p]}) return ST_OVERLAP;
    if (fused >= FREE_SLOTS) return ST_FULL;
    for (int k = fused; k > p; k--) begin
      fstart[k] = fstart[k-1];
      flen[k] = flen[k-1];
    end
    fstart[p] = ad;
    flen[p] = hlen[h];
    fused++;
    hvalid[h] = 1'b0;
    return ST_OK;
  endfunction

  function automatic int merge_touching();
    int i, removed;
    logic [63:0] sum;
    i = 0;
    removed = 0;
    while (i + 1 < fused) begin
      if ({32'd0, fstart[i]} + {32'd0, flen[i]} == {32'd0, fstart[i+1]}) begin
        sum = {32'd0, flen[i]} + {32'd0, flen[i+1]};
        flen[i] = (sum > SAT32) ? 32'hFFFF_FFFF : sum[31:0];
        for (int k = i + 1; k + 1 < fused; k++) begin
          fstart[k] = fstart[k+1];
          flen[k] = flen[k+1];
        end
        fused--;
        fstart[fused] = '0;
        flen[fused] = '0;
        removed++;
      end else begin
        i++;
      end
    end
    return removed;
  endfunction

  function automatic alloc_result_t predict_request(input logic [71:0] req);
    alloc_result_t r;
    cmd_t c;
    int merged;
    logic [63:0] ftot, htot;
    c = cmd_t'(req[1:0]);
    merged = 0;
    ftot = '0;
    htot = '0;
    r.status = ST_OK;
    r.granted = '0;
    case (c)
      CMD_RESERVE: r.status = reserve_block(req[33:2], r.granted);
      CMD_FREE:    r.status = release_block(req[65:34]);
      CMD_DEFRAG:  merged = merge_touching();
      default: ;
    endcase
    r.largest = '0;
    r.smallest = '0;
    for (int i = 0; i < fused; i++) begin
      ftot += flen[i];
      if (i == 0 || flen[i] > r.largest) r.largest = flen[i];
      if (i == 0 || flen[i] < r.smallest) r.smallest = flen[i];
    end
    for (int i = 0; i < HELD_SLOTS; i++)
      if (hvalid[i]) htot += hlen[i];
    r.merged = (merged > 15) ? 4'd15 : merged[3:0];
    r.free_total = (ftot > SAT32) ? 32'hFFFF_FFFF : ftot[31:0];
    r.held_total = (htot > SAT32) ? 32'hFFFF_FFFF : htot[31:0];
    r.free_count = fused[4:0];
    return r;
  endfunction

  initial begin
    errors = 0;
    result_no = 0;
    base_reg = '0;
    size_reg = 32'd65536;
    clear_tables();
  end

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst) begin
      base_reg = '0;
      size_reg = 32'd65536;
      clear_tables();
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_BASE) base_reg = cfg_data;
        else size_reg = cfg_data;
        clear_tables();
      end
      if (s_tvalid && s_tready) expected_results.push_back(predict_request(s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("MISMATCH result %0d: returned with nothing outstanding", result_no);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[2:0] != want.status)
            report("status", 32'(m_tdata[2:0]), 32'(want.status));
          if (m_tdata[34:3] != want.granted) report("granted", m_tdata[34:3], want.granted);
          if (m_tdata[38:35] != want.merged)
            report("merged", 32'(m_tdata[38:35]), 32'(want.merged));
          if (m_tdata[70:39] != want.free_total)
            report("free_total", m_tdata[70:39], want.free_total);
          if (m_tdata[102:71] != want.held_total)
            report("reserved_total", m_tdata[102:71], want.held_total);
          if (m_tdata[107:103] != want.free_count)
            report("free_entries", 32'(m_tdata[107:103]), 32'(want.free_count));
          if (m_tdata[139:108] != want.largest)
            report("largest_free", m_tdata[139:108], want.largest);
          if (m_tdata[171:140] != want.smallest)
            report("smallest_free", m_tdata[171:140], want.smallest);
        end
        result_no++;
      end
    end
  end

endmodule

FILE: bench/first_fit_block_allocator_tb.sv
// Top of the allocator bench. It makes the stimulus, drives the two
// streaming channels with random gaps and stalls, reconfigures the region
// between phases and gives the verdict from the checker's error and pending counts.
module first_fit_block_allocator_tb;
  import ffba_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic         clk = 1'b0;
  logic         rst;
  logic         cfg_we;
  logic         cfg_index;
  logic [31:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [71:0]  s_tdata;   // command[1:0], request_size[33:2], block_address[65:34]
  logic         m_tvalid;
  logic         m_tready;
  logic [175:0] m_tdata;   // status, granted, merged, totals, count, largest, smallest
  int           errors;
  int           pending;

  // Commands in flight, so that a granted address can be kept for a later
  // free when its result comes back.
  cmd_t         inflight_cmds[$];
  logic [31:0]  granted_addrs[$];
  logic [31:0]  region_len;
  bit           hold_request;
  int           cycles;
  int           sent;
  int           cmd_seen[4];
  int           status_seen[8];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  first_fit_block_allocator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  first_fit_block_allocator_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .pending(pending)
  );

  // A run that hangs anywhere ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Bookkeeping of requests and results, seen from the bench side.
  always @(posedge clk) begin
    cmd_t c;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        inflight_cmds.push_back(cmd_t'(s_tdata[1:0]));
        cmd_seen[s_tdata[1:0]]++;
      end
      if (m_tvalid && m_tready && inflight_cmds.size() > 0) begin
        c = inflight_cmds.pop_front();
        status_seen[m_tdata[2:0]]++;
        if (c == CMD_RESERVE && m_tdata[2:0] == ST_OK) granted_addrs.push_back(m_tdata[34:3]);
      end
    end
  end

  // Receiver: a random stall before each result, and once in a while a long
  // hold-off so that the block backs up and stops taking requests.
  initial begin
    int stall;
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (600) @(posedge clk);
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic send_request(input cmd_t c, input logic [31:0] sz, input logic [31:0] ad,
                              input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= {6'd0, ad, sz, c};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Both registers are written back to back; each write resets the tables.
  task automatic set_region(input logic [31:0] base, input logic [31:0] len);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_BASE;
    cfg_data <= base;
    @(posedge clk);
    cfg_index <= CFG_SIZE;
    cfg_data <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    region_len = len;
    granted_addrs.delete();
  endtask

  // Random traffic: mostly reserves of sizes that fit and frees of blocks
  // that were granted, with defragments, idle commands and noise mixed in.
  task automatic random_requests(input int count, input bit burst);
    int pick, idx;
    logic [31:0] sz, ad, scale;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      sz = $urandom;
      ad = $urandom;
      scale = (region_len >> 4) + 1;
      if (pick < 45) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) sz = $urandom_range(0, scale);
        else if (pick == 8) sz = '0;
        send_request(CMD_RESERVE, sz, ad, burst);
      end else if (pick < 78) begin
        if (granted_addrs.size() > 0 && $urandom_range(0, 9) < 8) begin
          idx = $urandom_range(0, granted_addrs.size() - 1);
          ad = granted_addrs[idx];
          granted_addrs.delete(idx);
        end
        send_request(CMD_FREE, sz, ad, burst);
      end else if (pick < 88) begin
        send_request(CMD_DEFRAG, sz, ad, burst);
      end else begin
        send_request(CMD_NOP, sz, ad, burst);
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_BASE;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    hold_request = 1'b0;
    cycles = 0;
    sent = 0;
    region_len = 32'd65536;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on the reset region: a zero request, no fit,
    // frees that are not held, overlap with a zero-length block at a free
    // start, the held table filling up, idle command and defragment.
    send_request(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_request(CMD_RESERVE, 32'd0, 32'd0, 0);
    send_request(CMD_FREE, 32'd0, 32'd0, 0);
    send_request(CMD_RESERVE, 32'hFFFF_FFFF, 32'd0, 0);
    send_request(CMD_FREE, 32'd0, 32'h1234_5678, 0);
    for (int i = 0; i < 16; i++) send_request(CMD_RESERVE, 32'h100, 32'd0, 1);
    send_request(CMD_FREE, 32'd0, 32'h100, 0);
    send_request(CMD_FREE, 32'd0, 32'h300, 0);
    send_request(CMD_DEFRAG, 32'd0, 32'd0, 0);

    // Pressure: the receiver stops while requests keep coming back to back.
    hold_request = 1'b1;
    random_requests(120, 1);

    set_region(32'hFFFF_FF00, 32'h0000_1000);   // carving wraps past the top
    send_request(CMD_RESERVE, 32'h200, 32'd0, 0);
    send_request(CMD_RESERVE, 32'h200, 32'd0, 0);
    send_request(CMD_FREE, 32'd0, 32'hFFFF_FF00, 0);
    send_request(CMD_FREE, 32'd0, 32'h0000_0100, 0);
    send_request(CMD_DEFRAG, 32'd0, 32'd0, 0);
    random_requests(80, 0);

    set_region(32'h0000_0000, 32'hFFFF_FFFF);   // whole space, totals saturate
    random_requests(90, 0);

    set_region(32'h0000_1000, 32'h0000_0000);   // empty region
    random_requests(40, 0);

    set_region($urandom, $urandom_range(64, 4096));
    random_requests(120, 0);

    wait_idle();
    repeat (40) @(posedge clk);
    $display("sent %0d requests: %0d reserve, %0d free, %0d defragment, %0d idle",
             sent, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
    $display("statuses: ok %0d, no fit %0d, not held %0d, overlap %0d, full %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: first_fit_block_allocator.f
hdl/ffba_pkg.sv
hdl/ffba_cell.sv
hdl/ffba_chain.sv
hdl/first_fit_block_allocator.sv
bench/first_fit_block_allocator_checker.sv
bench/first_fit_block_allocator_tb.sv
